@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the motion profile RTL.
// Needs only a clock and an active-low reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, off while reset is held.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property at each rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/vrmp_pkg.sv @@
// Shared types and constants for the motion profile generator.
// Used by the controller, the datapath and the top level.
package vrmp_pkg;

    localparam int CMD_W         = 2;
    localparam int DUR_W         = 16;
    localparam int DSQ_W         = 2 * DUR_W;
    localparam int POS_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 2'd0,
        CMD_SET_DEST = 2'd1,
        CMD_SET_CUR  = 2'd2,
        CMD_SET_DUR  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOAD,
        OP_DIST,
        OP_STOP,
        OP_MOVE,
        OP_MUL_SQ,
        OP_MUL_DA,
        OP_UPD,
        OP_ACC_ONE,
        OP_ACC_MAX,
        OP_MUL_DUR,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic at_target;
        logic dur_zero;
        logic div_last;
    } dp_stat_t;

endpackage

@@ hw/rtl/value_relaxation_motion_profile.sv @@
// Channel | Direction | tdata fields (low bit first)                 | tuser fields
// s_      | in        | value[POS_WIDTH-1:0], duration[15:0], pad    | cmd[1:0]
// m_      | out       | current_value[POS_WIDTH-1:0], moving, pad    | none
// One word at a time: set destination and set current value load a register; a tick
// measures the distance, stops at the destination or else moves and updates the speed
// (one shared multiplier used twice); set duration ends at the destination or with zero
// duration, else runs the one-bit-per-cycle restoring divider. Reset (aresetn low,
// synchronous) clears position, target and speed and sets acceleration to one. A new word
// is taken while a result waits; a stalled result holds only the controller's final state.
// Top level of the motion profile generator; depends on vrmp_pkg,
// vrmp_ctrl and vrmp_datapath.
module value_relaxation_motion_profile #(
    parameter int POS_WIDTH = vrmp_pkg::POS_WIDTH_DEF,
    parameter int FRAC_BITS = vrmp_pkg::FRAC_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // value, duration
    input  logic [((POS_WIDTH + vrmp_pkg::DUR_W + 7) / 8) * 8 - 1:0] s_tdata,
    // cmd
    input  logic [vrmp_pkg::CMD_W-1:0]                s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // current_value, moving
    output logic [((POS_WIDTH + 1 + 7) / 8) * 8 - 1:0]  m_tdata
);
    import vrmp_pkg::*;

    localparam int OUT_TW = ((POS_WIDTH + 1 + 7) / 8) * 8;

    dp_cmd_t                dp_cmd;
    dp_stat_t               dp_stat;
    logic [POS_WIDTH-1:0]   out_value;
    logic                   out_moving;

    vrmp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat)
    );

    vrmp_datapath #(
        .POS_WIDTH (POS_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_cmd      (s_tuser),
        .in_value    (s_tdata[POS_WIDTH-1:0]),
        .in_duration (s_tdata[POS_WIDTH+DUR_W-1:POS_WIDTH]),
        .dp_cmd      (dp_cmd),
        .dp_stat     (dp_stat),
        .out_value   (out_value),
        .out_moving  (out_moving)
    );

    assign m_tdata = OUT_TW'({out_moving, out_value});

endmodule

@@ hw/rtl/vrmp_datapath.sv @@
// Datapath: position, speed and acceleration state, shared multiplier,
// restoring divider and output payload register. Depends on vrmp_pkg.
`include "assert_macros.svh"

module vrmp_datapath #(
    parameter int POS_WIDTH = vrmp_pkg::POS_WIDTH_DEF,
    parameter int FRAC_BITS = vrmp_pkg::FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [vrmp_pkg::CMD_W-1:0] in_cmd,
    input  logic [POS_WIDTH-1:0]       in_value,
    input  logic [vrmp_pkg::DUR_W-1:0] in_duration,
    input  vrmp_pkg::dp_cmd_t          dp_cmd,
    output vrmp_pkg::dp_stat_t         dp_stat,
    output logic [POS_WIDTH-1:0]       out_value,
    output logic                       out_moving
);
    import vrmp_pkg::*;

    localparam int MUL_W = (POS_WIDTH > DUR_W) ? POS_WIDTH : DUR_W;
    localparam int QW    = POS_WIDTH + 2;
    localparam int CNT_W = $clog2(QW);
    localparam logic [POS_WIDTH-1:0] MAG_MAX = '1;
    localparam logic [POS_WIDTH-1:0] ONE_VAL = (FRAC_BITS >= POS_WIDTH) ? MAG_MAX :
        ({{(POS_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS);
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(QW - 1);

    cmd_t                   cmd_reg;
    logic [POS_WIDTH-1:0]   value_reg;
    logic [DUR_W-1:0]       dur_reg;
    logic [POS_WIDTH-1:0]   cur_reg;
    logic [POS_WIDTH-1:0]   tgt_reg;
    logic [POS_WIDTH-1:0]   speed_reg;
    logic [POS_WIDTH-1:0]   accel_reg;
    logic [POS_WIDTH-1:0]   dist_reg;
    logic                   dir_down_reg;
    logic                   at_tgt_reg;
    logic [POS_WIDTH-1:0]   d_reg;
    logic                   moving_reg;
    logic [2*MUL_W-1:0]     sq_reg;
    logic [2*MUL_W-1:0]     prod_reg;
    logic [DSQ_W-1:0]       rem_reg;
    logic [QW-1:0]          q_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [POS_WIDTH-1:0]   out_value_reg;
    logic                   out_moving_reg;

    logic [POS_WIDTH:0]     diff;
    logic [POS_WIDTH:0]     diff_neg;
    logic                   speed_ge;
    logic [POS_WIDTH-1:0]   cur_next;
    logic [POS_WIDTH-1:0]   d_next;
    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic [2*MUL_W-1:0]     prod;
    logic                   grow;
    logic [POS_WIDTH:0]     speed_sum;
    logic [POS_WIDTH-1:0]   speed_raw;
    logic [POS_WIDTH-1:0]   speed_next;
    logic [DSQ_W-1:0]       divisor;
    logic [DSQ_W:0]         trial;
    logic [DSQ_W:0]         trial_sub;
    logic                   trial_ge;
    logic [DSQ_W-1:0]       rem_next;
    logic [POS_WIDTH-1:0]   acc_quot;
    logic [POS_WIDTH-1:0]   acc_next;

    always_comb begin
        diff     = {cur_reg[POS_WIDTH-1], cur_reg} - {tgt_reg[POS_WIDTH-1], tgt_reg};
        diff_neg = -diff;
        speed_ge = (speed_reg >= dist_reg);
        if (speed_ge) begin
            cur_next = tgt_reg;
            d_next   = '0;
        end else begin
            cur_next = dir_down_reg ? (cur_reg - speed_reg) : (cur_reg + speed_reg);
            d_next   = dist_reg - speed_reg;
        end
    end

    always_comb begin
        case (dp_cmd.op)
            OP_MUL_SQ: begin
                mul_a = MUL_W'(speed_reg);
                mul_b = MUL_W'(speed_reg);
            end
            OP_MUL_DA: begin
                mul_a = MUL_W'(d_reg);
                mul_b = MUL_W'(accel_reg);
            end
            default: begin
                mul_a = MUL_W'(dur_reg);
                mul_b = MUL_W'(dur_reg);
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_comb begin
        grow      = (sq_reg < prod_reg);
        speed_sum = {1'b0, speed_reg} + {1'b0, accel_reg};
        if (grow) begin
            speed_raw = speed_sum[POS_WIDTH] ? MAG_MAX : speed_sum[POS_WIDTH-1:0];
        end else if (speed_reg > accel_reg) begin
            speed_raw = speed_reg - accel_reg;
        end else begin
            speed_raw = '0;
        end
        speed_next = (speed_raw < ONE_VAL) ? ONE_VAL : speed_raw;
    end

    always_comb begin
        divisor   = prod_reg[DSQ_W-1:0];
        trial     = {rem_reg, q_reg[QW-1]};
        trial_sub = trial - {1'b0, divisor};
        trial_ge  = (trial >= {1'b0, divisor});
        rem_next  = trial_ge ? trial_sub[DSQ_W-1:0] : trial[DSQ_W-1:0];
        acc_quot  = (q_reg[QW-1:QW-2] != 2'b00) ? MAG_MAX : q_reg[POS_WIDTH-1:0];
        acc_next  = (acc_quot < ONE_VAL) ? ONE_VAL : acc_quot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg   <= '0;
            tgt_reg   <= '0;
            speed_reg <= '0;
            accel_reg <= ONE_VAL;
        end else begin
            case (dp_cmd.op)
                OP_LOAD: begin
                    if (cmd_reg == CMD_SET_DEST) begin
                        tgt_reg <= value_reg;
                    end else begin
                        cur_reg <= value_reg;
                    end
                end
                OP_STOP:     speed_reg <= '0;
                OP_MOVE:     cur_reg   <= cur_next;
                OP_UPD:      speed_reg <= speed_next;
                OP_ACC_ONE:  accel_reg <= ONE_VAL;
                OP_ACC_MAX:  accel_reg <= MAG_MAX;
                OP_DIV_END:  accel_reg <= acc_next;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (dp_cmd.op)
            OP_LATCH: begin
                cmd_reg    <= cmd_t'(in_cmd);
                value_reg  <= in_value;
                dur_reg    <= in_duration;
                moving_reg <= 1'b0;
            end
            OP_DIST: begin
                dist_reg     <= diff[POS_WIDTH] ? diff_neg[POS_WIDTH-1:0] : diff[POS_WIDTH-1:0];
                dir_down_reg <= !diff[POS_WIDTH] && (diff != '0);
                at_tgt_reg   <= (diff == '0);
            end
            OP_MOVE: begin
                d_reg      <= d_next;
                moving_reg <= 1'b1;
            end
            OP_MUL_SQ:  sq_reg   <= prod;
            OP_MUL_DA:  prod_reg <= prod;
            OP_MUL_DUR: prod_reg <= prod;
            OP_DIV_INIT: begin
                rem_reg <= '0;
                q_reg   <= {dist_reg, 2'b00};
                cnt_reg <= CNT_INIT;
            end
            OP_DIV_STEP: begin
                rem_reg <= rem_next;
                q_reg   <= {q_reg[QW-2:0], trial_ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            OP_OUT: begin
                out_value_reg  <= cur_reg;
                out_moving_reg <= moving_reg;
            end
            default: begin
            end
        endcase
    end

    assign dp_stat.cmd       = cmd_reg;
    assign dp_stat.at_target = at_tgt_reg;
    assign dp_stat.dur_zero  = (dur_reg == '0);
    assign dp_stat.div_last  = (cnt_reg == '0);

    assign out_value  = out_value_reg;
    assign out_moving = out_moving_reg;

    `ASSERT_CLK(a_accel_floor, aclk, aresetn, accel_reg >= ONE_VAL, "accel below one")
    `ASSERT_CLK(a_speed_floor, aclk, aresetn,
        (dp_cmd.op == OP_UPD) |=> (speed_reg >= ONE_VAL), "speed below one after update")
    `ASSERT_CLK(a_rem_bound, aclk, aresetn,
        (dp_cmd.op == OP_DIV_STEP) |=> (rem_reg < prod_reg[DSQ_W-1:0]),
        "remainder not below divisor")

endmodule

@@ hw/rtl/vrmp_ctrl.sv @@
// Controller: sequences one command word through the datapath and owns
// the handshake on both channels. Depends on vrmp_pkg.
`include "assert_macros.svh"

module vrmp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output vrmp_pkg::dp_cmd_t  dp_cmd,
    input  vrmp_pkg::dp_stat_t dp_stat
);
    import vrmp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_DIST,
        S_BRANCH,
        S_MUL_SQ,
        S_MUL_DA,
        S_UPD,
        S_DIV_INIT,
        S_DIV,
        S_DIV_END,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_load;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        case (state_reg)
            S_IDLE:     dp_cmd.op = s_tvalid ? OP_LATCH : OP_NONE;
            S_LOAD:     dp_cmd.op = OP_LOAD;
            S_DIST:     dp_cmd.op = OP_DIST;
            S_BRANCH: begin
                if (dp_stat.cmd == CMD_TICK) begin
                    dp_cmd.op = dp_stat.at_target ? OP_STOP : OP_MOVE;
                end else if (dp_stat.at_target) begin
                    dp_cmd.op = OP_ACC_ONE;
                end else if (dp_stat.dur_zero) begin
                    dp_cmd.op = OP_ACC_MAX;
                end else begin
                    dp_cmd.op = OP_MUL_DUR;
                end
            end
            S_MUL_SQ:   dp_cmd.op = OP_MUL_SQ;
            S_MUL_DA:   dp_cmd.op = OP_MUL_DA;
            S_UPD:      dp_cmd.op = OP_UPD;
            S_DIV_INIT: dp_cmd.op = OP_DIV_INIT;
            S_DIV:      dp_cmd.op = OP_DIV_STEP;
            S_DIV_END:  dp_cmd.op = OP_DIV_END;
            S_DONE:     dp_cmd.op = out_load ? OP_OUT : OP_NONE;
            default:    dp_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (dp_stat.cmd inside {CMD_SET_DEST, CMD_SET_CUR}) begin
                        state_reg <= S_LOAD;
                    end else begin
                        state_reg <= S_DIST;
                    end
                end
                S_LOAD:   state_reg <= S_DONE;
                S_DIST:   state_reg <= S_BRANCH;
                S_BRANCH: begin
                    if (dp_stat.at_target) begin
                        state_reg <= S_DONE;
                    end else if (dp_stat.cmd == CMD_TICK) begin
                        state_reg <= S_MUL_SQ;
                    end else if (dp_stat.dur_zero) begin
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_DIV_INIT;
                    end
                end
                S_MUL_SQ:   state_reg <= S_MUL_DA;
                S_MUL_DA:   state_reg <= S_UPD;
                S_UPD:      state_reg <= S_DONE;
                S_DIV_INIT: state_reg <= S_DIV;
                S_DIV: begin
                    if (dp_stat.div_last) begin
                        state_reg <= S_DIV_END;
                    end
                end
                S_DIV_END:  state_reg <= S_DONE;
                S_DONE: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_out_from_done, aclk, aresetn,
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE), "result raised outside done")
    `ASSERT_CLK(a_div_exit, aclk, aresetn,
        (state_reg == S_DIV && dp_stat.div_last) |=> (state_reg == S_DIV_END),
        "divider did not finish")

endmodule

@@ dv/tb_top.sv @@
// Stream-level testbench for value_relaxation_motion_profile: directed and random commands.
// A scoreboard class predicts position and moving flag per word; depends on vrmp_pkg and the RTL.
module tb_top;
    import vrmp_pkg::*;

    localparam int POS_W  = POS_WIDTH_DEF;
    localparam int FRAC_W = FRAC_BITS_DEF;
    localparam int S_W    = ((POS_W + DUR_W + 7) / 8) * 8;
    localparam int M_W    = ((POS_W + 1 + 7) / 8) * 8;
    localparam longint unsigned MAG_MAX  = (64'd1 << POS_W) - 1;
    localparam longint unsigned ONE_RAW  = 64'd1 << FRAC_W;
    localparam longint unsigned UNIT     = (ONE_RAW > MAG_MAX) ? MAG_MAX : ONE_RAW;
    localparam int              N_WORDS  = 1450;

    typedef struct packed {
        logic             moving;
        logic [POS_W-1:0] position;
    } motion_result_t;

    class motion_scoreboard;
        longint          pos;
        longint          dest;
        longint unsigned speed;
        longint unsigned accel;
        motion_result_t  expected_q[$];
        int              errors;

        function new();
            pos    = 0;
            dest   = 0;
            speed  = 0;
            accel  = UNIT;
            errors = 0;
        endfunction

        function longint unsigned remaining();
            return (pos > dest) ? longint'(pos - dest) : longint'(dest - pos);
        endfunction

        function logic step_toward();
            longint          nxt;
            longint unsigned d;
            if (pos == dest) begin
                speed = 0;
                return 1'b0;
            end
            if (pos > dest) begin
                nxt = pos - longint'(speed);
                if (nxt < dest) nxt = dest;
            end else begin
                nxt = pos + longint'(speed);
                if (nxt > dest) nxt = dest;
            end
            pos = nxt;
            d = remaining();
            if (speed * speed < d * accel) begin
                speed = speed + accel;
                if (speed > MAG_MAX) speed = MAG_MAX;
            end else begin
                speed = (speed > accel) ? speed - accel : 0;
            end
            if (speed < UNIT) speed = UNIT;
            return 1'b1;
        endfunction

        function void derive_accel(logic [15:0] dur);
            longint unsigned delta;
            longint unsigned acc;
            longint unsigned t;
            delta = remaining();
            t     = 64'(dur);
            if (delta == 0) begin
                acc = 0;
            end else if (t == 0) begin
                acc = MAG_MAX;
            end else begin
                acc = (4 * delta) / (t * t);
                if (acc > MAG_MAX) acc = MAG_MAX;
            end
            if (acc < UNIT) acc = UNIT;
            accel = acc;
        endfunction

        function void note_input(cmd_t c, logic [POS_W-1:0] v, logic [15:0] dur);
            motion_result_t r;
            r.moving = 1'b0;
            case (c)
                CMD_TICK:     r.moving = step_toward();
                CMD_SET_DEST: dest = longint'($signed(v));
                CMD_SET_CUR:  pos = longint'($signed(v));
                default:      derive_accel(dur);
            endcase
            r.position = pos[POS_W-1:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [POS_W-1:0] val, logic mv);
            motion_result_t e;
            if (expected_q.size() == 0) begin
                $error("unexpected word: current_value %0d moving %0b", $signed(val), mv);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (val !== e.position) begin
                $error("current_value: expected %0d, got %0d",
                       $signed(e.position), $signed(val));
                errors++;
            end
            if (mv !== e.moving) begin
                $error("moving: expected %0b, got %0b", e.moving, mv);
                errors++;
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata;
    logic [CMD_W-1:0] s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [M_W-1:0]   m_tdata;

    motion_scoreboard sb = new();
    bit               quiet;
    int               sent;
    int               stall_left;

    value_relaxation_motion_profile dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return POS_W'($urandom);
        if (r < 8) return POS_W'(int'($urandom_range(0, 8191)) - 4096);
        if (r == 8) return {1'b0, {(POS_W-1){1'b1}}};
        return {1'b1, {(POS_W-1){1'b0}}};
    endfunction

    function automatic logic [15:0] pick_duration();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 16'($urandom_range(1, 24));
        if (r == 7) return 16'd0;
        return 16'($urandom);
    endfunction

    task automatic send_word(cmd_t c, logic [POS_W-1:0] v, logic [15:0] dur);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({dur, v});
        s_tuser  <= c;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(c, v, dur);
        sent++;
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_word(CMD_TICK, POS_W'($urandom), 16'($urandom));
    endtask

    // Hold the result channel with random stalls.
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_left > 0 && !quiet) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = 0;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata[POS_W-1:0], m_tdata[POS_W]);
    end

    initial begin
        #(12 * 1000000);
        $display("tb_top failed");
        $finish;
    end

    initial begin
        int r;
        int k;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        quiet    = 1'b0;
        sent     = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // tick at rest, then a full-scale move with saturated acceleration
        send_word(CMD_TICK, '0, '0);
        send_word(CMD_SET_DEST, {1'b0, {(POS_W-1){1'b1}}}, 16'hFFFF);
        send_word(CMD_SET_CUR, {1'b1, {(POS_W-1){1'b0}}}, 16'hFFFF);
        send_word(CMD_SET_DUR, '1, 16'd0);
        send_ticks(3);
        // longest duration: acceleration drops to its floor
        send_word(CMD_SET_CUR, {1'b1, {(POS_W-1){1'b0}}}, 16'd0);
        send_word(CMD_SET_DUR, '0, 16'hFFFF);
        send_ticks(2);
        // zero duration at the destination
        send_word(CMD_SET_CUR, {1'b0, {(POS_W-1){1'b1}}}, 16'd0);
        send_word(CMD_SET_DUR, '0, 16'd0);
        // short downward move, then an upward move
        send_word(CMD_SET_DEST, '1, 16'd0);
        send_word(CMD_SET_CUR, '0, 16'd0);
        send_word(CMD_SET_DUR, '0, 16'd1);
        send_ticks(3);
        send_word(CMD_SET_CUR, 24'h000100, 16'd0);
        send_word(CMD_SET_DEST, 24'h00FF00, 16'd0);
        send_word(CMD_SET_DUR, '0, 16'd3);
        send_ticks(3);

        while (sent < N_WORDS) begin
            quiet = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 9);
            if (r < 7) begin
                if ($urandom_range(0, 1)) begin
                    send_word(CMD_SET_CUR, pick_position(), 16'($urandom));
                    send_word(CMD_SET_DEST, pick_position(), 16'($urandom));
                end else begin
                    send_word(CMD_SET_DEST, pick_position(), 16'($urandom));
                    if ($urandom_range(0, 2) != 0)
                        send_word(CMD_SET_CUR, pick_position(), 16'($urandom));
                end
                send_word(CMD_SET_DUR, POS_W'($urandom), pick_duration());
                k = $urandom_range(2, 40);
                send_ticks(k / 2);
                if ($urandom_range(0, 5) == 0)
                    send_word(CMD_SET_DUR, POS_W'($urandom), pick_duration());
                if ($urandom_range(0, 7) == 0)
                    send_word(CMD_SET_DEST, pick_position(), 16'($urandom));
                send_ticks(k - k / 2);
            end else begin
                repeat ($urandom_range(1, 6))
                    send_word(cmd_t'(CMD_W'($urandom_range(0, 3))), POS_W'($urandom),
                              16'($urandom));
            end
        end

        quiet = 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
